/* src/chi_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// chi_pkg
// Shared constants, codes and the node word layout for the chained hash index.
// ----------------------------------------------------------------------------
package chi_pkg;

  localparam int HOME_BUCKETS   = 100;
  localparam int OVERFLOW_DEPTH = 256;
  localparam int KEY_BITS       = 64;

  localparam int KEY_PORT_W = 64;
  localparam int OFF_W      = 15;
  localparam int KIND_W     = 2;
  localparam int STATUS_W   = 2;

  localparam int HB_W   = $clog2(HOME_BUCKETS);
  localparam int PA_W   = $clog2(OVERFLOW_DEPTH);
  localparam int LINK_W = $clog2(OVERFLOW_DEPTH + 1);
  localparam int PROD_W = 16;

  localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(OVERFLOW_DEPTH);

  // reciprocal for the home bucket reduction, q = (p * HASH_MUL) >> 32
  localparam logic [31:0] HASH_MUL =
    32'(((64'd1 << 32) + 64'(HOME_BUCKETS) - 64'd1) / 64'(HOME_BUCKETS));

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

  typedef struct packed {
    logic                dead;
    logic [KEY_BITS-1:0] key;
    logic [OFF_W-1:0]    offset;
    logic [LINK_W-1:0]   link;
  } node_t;

  localparam int NODE_W = $bits(node_t);

endpackage
`default_nettype wire

/* src/chi_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// chi_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module chi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* src/chi_hash.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// chi_hash
// Three-stage home bucket unit: byte product, reciprocal multiply, remainder.
// ----------------------------------------------------------------------------
module chi_hash
  import chi_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [7:0]      b0_i,
  input  wire logic [7:0]      b1_i,
  output logic                 valid_o,
  output logic      [HB_W-1:0] idx_o
);

  logic              vld1_q, vld2_q, vld3_q;
  logic [PROD_W-1:0] prod_q, prod2_q, quot_q;
  logic [PROD_W-1:0] prod_d, quot_d, rem_d;
  logic [47:0]       recip_prod;
  logic [HB_W-1:0]   idx_q;

  assign prod_d     = PROD_W'(b0_i * b1_i);
  assign recip_prod = 48'(prod_q) * 48'(HASH_MUL);
  assign quot_d     = recip_prod[47:32];
  assign rem_d      = prod2_q - PROD_W'(quot_q * HOME_BUCKETS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else begin
      vld1_q <= start_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    prod2_q <= prod_q;
    quot_q  <= quot_d;
    idx_q   <= rem_d[HB_W-1:0];
  end

  assign valid_o = vld3_q;
  assign idx_o   = idx_q;

endmodule
`default_nettype wire

/* src/chained_hash_index_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// chained_hash_index_core
// Hash index with separate chaining over a home RAM and an overflow pool RAM.
// ----------------------------------------------------------------------------
// Sequence: hash unit, home slot read, home check; then a walk and a node check
//   per overflow node read, a final walk step when the walk runs off the chain,
//   then append and link (no link when the pool is full). Unused kind: from idle.
// Throughput: one word at a time; busy stays high until the result is issued.
// Reset: all home slots empty, pool fill count zero; no clearing pass needed.
// The result strobe done_o lasts one cycle and cannot be stalled.
module chained_hash_index_core
  import chi_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [KIND_W-1:0]     kind_i,
  input  wire logic [KEY_PORT_W-1:0] key_i,
  input  wire logic [OFF_W-1:0]      record_offset_i,
  output logic                       done_o,
  output logic      [STATUS_W-1:0]   status_o,
  output logic      [OFF_W-1:0]      found_offset_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_HASH   = 3'd1;
  localparam logic [2:0] S_HRD    = 3'd2;
  localparam logic [2:0] S_HEV    = 3'd3;
  localparam logic [2:0] S_WALK   = 3'd4;
  localparam logic [2:0] S_PEV    = 3'd5;
  localparam logic [2:0] S_APPEND = 3'd6;
  localparam logic [2:0] S_LINK   = 3'd7;

  logic [2:0]              state_q, state_d;
  logic [KIND_W-1:0]       kind_q, kind_d;
  logic [KEY_BITS-1:0]     key_q, key_d;
  logic [OFF_W-1:0]        off_q, off_d;
  logic [HB_W-1:0]         idx_q, idx_d;
  node_t                   home_q, home_d;
  node_t                   tnode_q, tnode_d;
  logic [LINK_W-1:0]       cur_q, cur_d;
  logic [LINK_W-1:0]       tail_q, tail_d;
  logic [LINK_W-1:0]       steps_q, steps_d;
  logic [LINK_W-1:0]       fill_q, fill_d;
  logic [HOME_BUCKETS-1:0] valid_q, valid_d;
  logic                    done_q, done_d;
  logic [STATUS_W-1:0]     status_q, status_d;
  logic [OFF_W-1:0]        found_q, found_d;

  logic              accept;
  logic              known_kind;
  logic              hash_vld;
  logic [HB_W-1:0]   hash_idx;
  logic              h_we, h_re, p_we, p_re;
  logic [PA_W-1:0]   p_waddr;
  node_t             h_wdata, h_rdata, p_wdata, p_rdata;
  logic              link_ok;
  logic              is_insert, is_delete;

  assign accept     = start && !busy;
  assign known_kind = kind_i inside {KIND_INSERT, KIND_LOOKUP, KIND_DELETE};
  assign busy       = (state_q != S_IDLE);
  assign is_insert  = (kind_q == KIND_INSERT);
  assign is_delete  = (kind_q == KIND_DELETE);
  assign link_ok    = (cur_q < fill_q) && (steps_q < NIL_LINK);

  chi_hash u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(accept && known_kind),
    .b0_i   (key_i[7:0]),
    .b1_i   (key_i[15:8]),
    .valid_o(hash_vld),
    .idx_o  (hash_idx)
  );

  chi_ram #(.WIDTH(NODE_W), .DEPTH(HOME_BUCKETS)) u_home_ram (
    .clk_i  (clk_i),
    .we_i   (h_we),
    .waddr_i(idx_q),
    .wdata_i(h_wdata),
    .re_i   (h_re),
    .raddr_i(idx_q),
    .rdata_o(h_rdata)
  );

  chi_ram #(.WIDTH(NODE_W), .DEPTH(OVERFLOW_DEPTH)) u_pool_ram (
    .clk_i  (clk_i),
    .we_i   (p_we),
    .waddr_i(p_waddr),
    .wdata_i(p_wdata),
    .re_i   (p_re),
    .raddr_i(cur_q[PA_W-1:0]),
    .rdata_o(p_rdata)
  );

  always_comb begin
    state_d  = state_q;
    kind_d   = kind_q;
    key_d    = key_q;
    off_d    = off_q;
    idx_d    = idx_q;
    home_d   = home_q;
    tnode_d  = tnode_q;
    cur_d    = cur_q;
    tail_d   = tail_q;
    steps_d  = steps_q;
    fill_d   = fill_q;
    valid_d  = valid_q;
    done_d   = 1'b0;
    status_d = status_q;
    found_d  = found_q;
    h_we     = 1'b0;
    h_re     = 1'b0;
    h_wdata  = home_q;
    p_we     = 1'b0;
    p_re     = 1'b0;
    p_waddr  = cur_q[PA_W-1:0];
    p_wdata  = p_rdata;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          kind_d = kind_i;
          key_d  = key_i[KEY_BITS-1:0];
          off_d  = record_offset_i;
          if (known_kind) begin
            state_d = S_HASH;
          end else begin
            done_d   = 1'b1;
            status_d = STATUS_MISS;
            found_d  = '0;
          end
        end
      end
      S_HASH: begin
        if (hash_vld) begin
          idx_d   = hash_idx;
          state_d = S_HRD;
        end
      end
      S_HRD: begin
        h_re    = 1'b1;
        state_d = S_HEV;
      end
      S_HEV: begin
        home_d  = h_rdata;
        tail_d  = NIL_LINK;
        steps_d = '0;
        cur_d   = h_rdata.link;
        found_d = '0;
        if (is_insert) begin
          if (!valid_q[idx_q] || h_rdata.dead) begin
            h_we           = 1'b1;
            h_wdata.dead   = 1'b0;
            h_wdata.key    = key_q;
            h_wdata.offset = off_q;
            h_wdata.link   = valid_q[idx_q] ? h_rdata.link : NIL_LINK;
            valid_d[idx_q] = 1'b1;
            done_d         = 1'b1;
            status_d       = STATUS_OK;
            state_d        = S_IDLE;
          end else begin
            state_d = S_WALK;
          end
        end else if (!valid_q[idx_q]) begin
          done_d   = 1'b1;
          status_d = STATUS_MISS;
          state_d  = S_IDLE;
        end else if (h_rdata.key == key_q) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
          if (!h_rdata.dead) begin
            status_d = STATUS_OK;
            found_d  = h_rdata.offset;
            if (is_delete) begin
              h_we         = 1'b1;
              h_wdata      = h_rdata;
              h_wdata.dead = 1'b1;
            end
          end else begin
            status_d = STATUS_MISS;
          end
        end else begin
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (link_ok) begin
          p_re    = 1'b1;
          state_d = S_PEV;
        end else if (is_insert) begin
          state_d = S_APPEND;
        end else begin
          done_d   = 1'b1;
          status_d = STATUS_MISS;
          found_d  = '0;
          state_d  = S_IDLE;
        end
      end
      S_PEV: begin
        found_d = '0;
        if (is_insert) begin
          if (p_rdata.dead) begin
            p_we           = 1'b1;
            p_wdata.dead   = 1'b0;
            p_wdata.key    = key_q;
            p_wdata.offset = off_q;
            done_d         = 1'b1;
            status_d       = STATUS_OK;
            state_d        = S_IDLE;
          end else begin
            tail_d  = cur_q;
            tnode_d = p_rdata;
            cur_d   = p_rdata.link;
            steps_d = steps_q + 1'b1;
            state_d = S_WALK;
          end
        end else if (p_rdata.key == key_q) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
          if (!p_rdata.dead) begin
            status_d = STATUS_OK;
            found_d  = p_rdata.offset;
            if (is_delete) begin
              p_we         = 1'b1;
              p_wdata.dead = 1'b1;
            end
          end else begin
            status_d = STATUS_MISS;
          end
        end else begin
          cur_d   = p_rdata.link;
          steps_d = steps_q + 1'b1;
          state_d = S_WALK;
        end
      end
      S_APPEND: begin
        found_d = '0;
        if (fill_q == NIL_LINK) begin
          done_d   = 1'b1;
          status_d = STATUS_FULL;
          state_d  = S_IDLE;
        end else begin
          p_we           = 1'b1;
          p_waddr        = fill_q[PA_W-1:0];
          p_wdata.dead   = 1'b0;
          p_wdata.key    = key_q;
          p_wdata.offset = off_q;
          p_wdata.link   = NIL_LINK;
          cur_d          = fill_q;
          fill_d         = fill_q + 1'b1;
          state_d        = S_LINK;
        end
      end
      S_LINK: begin
        if (tail_q == NIL_LINK) begin
          h_we         = 1'b1;
          h_wdata      = home_q;
          h_wdata.link = cur_q;
        end else begin
          p_we         = 1'b1;
          p_waddr      = tail_q[PA_W-1:0];
          p_wdata      = tnode_q;
          p_wdata.link = cur_q;
        end
        done_d   = 1'b1;
        status_d = STATUS_OK;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      valid_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      valid_q <= valid_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    key_q    <= key_d;
    off_q    <= off_d;
    idx_q    <= idx_d;
    home_q   <= home_d;
    tnode_q  <= tnode_d;
    cur_q    <= cur_d;
    tail_q   <= tail_d;
    steps_q  <= steps_d;
    status_q <= status_d;
    found_q  <= found_d;
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign found_offset_o = found_q;

`ifndef NO_ASSERTIONS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result issued while busy");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= NIL_LINK)
    else $error("pool fill count beyond pool depth");

  a_full_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STATUS_FULL) |-> (fill_q == NIL_LINK))
    else $error("pool full reported with free nodes");

  a_offset_zero_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != STATUS_OK) |-> (found_offset_o == '0))
    else $error("nonzero offset without a match");

  a_fill_grows_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != $past(fill_q)) |-> (fill_q == $past(fill_q) + 1'b1 && state_q == S_LINK))
    else $error("pool fill changed outside an append");
`endif

endmodule
`default_nettype wire

/* test/chained_hash_index_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_index_core_tb
// Drives insert, lookup, delete and spare-kind words into the hash index and
// checks every answer against an in-bench chained table (typed directed words
// against their own answers): a directed table of corner words first, then
// random bursts that fill the overflow pool, reuse tombstones and repeat keys.
// ----------------------------------------------------------------------------
module chained_hash_index_core_tb;
  import chi_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int RAND_WORDS = 1726;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int KEY_LOG_MAX = 48;

  typedef enum logic [1:0] {SLOT_EMPTY, SLOT_LIVE, SLOT_DEAD} slot_e;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OFF_W-1:0]    offset;
  } answer_t;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [KEY_PORT_W-1:0] key;
    logic [OFF_W-1:0]      offset;
    logic                  typed;
    logic [STATUS_W-1:0]   status;
    logic [OFF_W-1:0]      found;
  } vector_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic [KIND_W-1:0]     kind_i;
  logic [KEY_PORT_W-1:0] key_i;
  logic [OFF_W-1:0]      record_offset_i;
  logic                  done_o;
  logic [STATUS_W-1:0]   status_o;
  logic [OFF_W-1:0]      found_offset_o;

  // shadow hash table
  slot_e               slot_state [HOME_BUCKETS];
  logic [KEY_BITS-1:0] slot_key   [HOME_BUCKETS];
  logic [OFF_W-1:0]    slot_off   [HOME_BUCKETS];
  int unsigned         slot_link  [HOME_BUCKETS];
  bit                  node_dead  [OVERFLOW_DEPTH];
  logic [KEY_BITS-1:0] node_key   [OVERFLOW_DEPTH];
  logic [OFF_W-1:0]    node_off   [OVERFLOW_DEPTH];
  int unsigned         node_link  [OVERFLOW_DEPTH];
  int unsigned         fill_count;

  answer_t             due_answers [$];
  logic [KEY_PORT_W-1:0] key_log [$];
  int                  err_cnt = 0;
  int unsigned         cycle_cnt = 0;
  bit                  cur_typed = 1'b0;
  answer_t             cur_answer = '0;

  vector_t dir_tab [24] = '{
    '{KIND_LOOKUP, 64'h0, 15'h0000, 1'b1, STATUS_MISS, 15'h0000},
    '{KIND_DELETE, 64'hFFFF_FFFF_FFFF_FFFF, 15'h0000, 1'b1, STATUS_MISS, 15'h0000},
    '{KIND_SPARE, 64'hFFFF_FFFF_FFFF_FFFF, 15'h7FFF, 1'b1, STATUS_MISS, 15'h0000},
    '{KIND_INSERT, 64'h0, 15'h0000, 1'b1, STATUS_OK, 15'h0000},
    '{KIND_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 15'h7FFF, 1'b1, STATUS_OK, 15'h0000},
    '{KIND_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 15'h0000, 1'b1, STATUS_OK, 15'h7FFF},
    '{KIND_LOOKUP, 64'h0, 15'h7FFF, 1'b1, STATUS_OK, 15'h0000},
    '{KIND_INSERT, 64'h0000_0000_0000_1405, 15'h1234, 1'b0, STATUS_OK, 15'h0000},
    '{KIND_INSERT, 64'hAA00_0000_0000_0A0A, 15'h2222, 1'b0, STATUS_OK, 15'h0000},
    '{KIND_LOOKUP, 64'h0000_0000_0000_1405, 15'h0000, 1'b0, STATUS_OK, 15'h0000},
    '{KIND_DELETE, 64'h0000_0000_0000_1405, 15'h0000, 1'b0, STATUS_OK, 15'h0000},
    '{KIND_LOOKUP, 64'h0000_0000_0000_1405, 15'h0000, 1'b0, STATUS_OK, 15'h0000},
    '{KIND_DELETE, 64'h0000_0000_0000_1405, 15'h0000, 1'b0, STATUS_OK, 15'h0000},
    '{KIND_INSERT, 64'h5555_0000_0000_1405, 15'h0ABC, 1'b0, STATUS_OK, 15'h0000},
    '{KIND_LOOKUP, 64'h5555_0000_0000_1405, 15'h0000, 1'b0, STATUS_OK, 15'h0000},
    '{KIND_DELETE, 64'h0, 15'h0000, 1'b0, STATUS_OK, 15'h0000},
    '{KIND_LOOKUP, 64'h0, 15'h0000, 1'b0, STATUS_OK, 15'h0000},
    '{KIND_INSERT, 64'h8000_0000_0000_0A0A, 15'h4000, 1'b0, STATUS_OK, 15'h0000},
    '{KIND_LOOKUP, 64'hAA00_0000_0000_0A0A, 15'h0000, 1'b0, STATUS_OK, 15'h0000},
    '{KIND_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 15'h0001, 1'b0, STATUS_OK, 15'h0000},
    '{KIND_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 15'h0000, 1'b0, STATUS_OK, 15'h0000},
    '{KIND_DELETE, 64'hFFFF_FFFF_FFFF_FFFF, 15'h0000, 1'b0, STATUS_OK, 15'h0000},
    '{KIND_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 15'h0000, 1'b0, STATUS_OK, 15'h0000},
    '{KIND_SPARE, 64'h0, 15'h0000, 1'b1, STATUS_MISS, 15'h0000}
  };

  chained_hash_index_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .kind_i          (kind_i),
    .key_i           (key_i),
    .record_offset_i (record_offset_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .found_offset_o  (found_offset_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic int unsigned bucket_of(input logic [KEY_BITS-1:0] k);
    int unsigned prod;
    prod = 32'(k[7:0]) * 32'(k[15:8]);
    return prod % HOME_BUCKETS;
  endfunction

  function automatic bit link_live(input int unsigned l);
    return l < fill_count && l < OVERFLOW_DEPTH;
  endfunction

  // applies one word to the shadow table and returns the answer it gives
  function automatic void apply_index_op(input logic [KIND_W-1:0] kind,
                                         input logic [KEY_PORT_W-1:0] key,
                                         input logic [OFF_W-1:0] off,
                                         output answer_t ans);
    logic [KEY_BITS-1:0] k;
    int unsigned h;
    int unsigned cur;
    int unsigned tail;
    int unsigned node;
    k = key[KEY_BITS-1:0];
    h = bucket_of(k);
    ans.offset = '0;
    ans.status = STATUS_MISS;
    case (kind)
      KIND_INSERT: begin
        ans.status = STATUS_OK;
        if (slot_state[h] != SLOT_LIVE) begin
          if (slot_state[h] == SLOT_EMPTY) slot_link[h] = OVERFLOW_DEPTH;
          slot_state[h] = SLOT_LIVE;
          slot_key[h] = k;
          slot_off[h] = off;
          return;
        end
        cur = slot_link[h];
        tail = OVERFLOW_DEPTH;
        for (int steps = 0; steps < OVERFLOW_DEPTH && link_live(cur); steps++) begin
          if (node_dead[cur]) begin
            node_dead[cur] = 1'b0;
            node_key[cur] = k;
            node_off[cur] = off;
            return;
          end
          tail = cur;
          cur = node_link[cur];
        end
        if (fill_count >= OVERFLOW_DEPTH) begin
          ans.status = STATUS_FULL;
          return;
        end
        node = fill_count;
        fill_count++;
        node_dead[node] = 1'b0;
        node_key[node] = k;
        node_off[node] = off;
        node_link[node] = OVERFLOW_DEPTH;
        if (tail == OVERFLOW_DEPTH) slot_link[h] = node;
        else node_link[tail] = node;
      end
      KIND_LOOKUP, KIND_DELETE: begin
        if (slot_state[h] == SLOT_EMPTY) return;
        if (slot_key[h] == k) begin
          if (slot_state[h] == SLOT_LIVE) begin
            ans.status = STATUS_OK;
            ans.offset = slot_off[h];
            if (kind == KIND_DELETE) slot_state[h] = SLOT_DEAD;
          end
          return;
        end
        cur = slot_link[h];
        for (int steps = 0; steps < OVERFLOW_DEPTH && link_live(cur); steps++) begin
          if (node_key[cur] == k) begin
            if (!node_dead[cur]) begin
              ans.status = STATUS_OK;
              ans.offset = node_off[cur];
              if (kind == KIND_DELETE) node_dead[cur] = 1'b1;
            end
            return;
          end
          cur = node_link[cur];
        end
      end
      default: ans.status = STATUS_MISS;
    endcase
  endfunction

  // check answers, then log the word taken at this edge
  always @(posedge clk_i) begin
    answer_t want;
    answer_t got;
    if (rst_ni) begin
      if (done_o) begin
        if (due_answers.size() == 0) begin
          $error("answer with none pending: status %0d, offset %0h", status_o,
                 found_offset_o);
          err_cnt++;
        end else begin
          want = due_answers.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status_o);
            err_cnt++;
          end
          if (found_offset_o !== want.offset) begin
            $error("found_offset: expected %0h, actual %0h", want.offset,
                   found_offset_o);
            err_cnt++;
          end
        end
      end
      if (start && !busy) begin
        apply_index_op(kind_i, key_i, record_offset_i, got);
        due_answers.push_back(cur_typed ? cur_answer : got);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_word(input logic [KIND_W-1:0] kind, input logic [KEY_PORT_W-1:0] key,
                           input logic [OFF_W-1:0] off, input bit typed,
                           input answer_t ans);
    @(negedge clk_i);
    start <= 1'b1;
    kind_i <= kind;
    key_i <= key;
    record_offset_i <= off;
    cur_typed = typed;
    cur_answer = ans;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic idle_for(input int n);
    if (n > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain;
    idle_for(1);
    while (due_answers.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [KIND_W-1:0]     kind;
    logic [KEY_PORT_W-1:0] key;
    int                    pick;
    int                    burst_left;
    rst_ni = 1'b0;
    start = 1'b0;
    kind_i = KIND_INSERT;
    key_i = '0;
    record_offset_i = '0;
    fill_count = 0;
    for (int i = 0; i < HOME_BUCKETS; i++) slot_state[i] = SLOT_EMPTY;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) begin
      send_word(dir_tab[i].kind, dir_tab[i].key, dir_tab[i].offset, dir_tab[i].typed,
                '{dir_tab[i].status, dir_tab[i].found});
      idle_for($urandom_range(0, 2));
    end
    drain();

    burst_left = 0;
    for (int i = 0; i < RAND_WORDS; i++) begin
      pick = $urandom_range(0, 99);
      if (i < RAND_WORDS / 2)
        kind = pick < 55 ? KIND_INSERT : pick < 75 ? KIND_LOOKUP :
               pick < 95 ? KIND_DELETE : KIND_SPARE;
      else
        kind = pick < 35 ? KIND_INSERT : pick < 65 ? KIND_LOOKUP :
               pick < 95 ? KIND_DELETE : KIND_SPARE;
      // known keys give hits, tombstones and duplicates
      if (key_log.size() != 0 && (kind == KIND_INSERT ? $urandom_range(0, 6) == 0
                                                      : $urandom_range(0, 3) != 0))
        key = key_log[$urandom_range(0, key_log.size() - 1)];
      else
        key = {$urandom, $urandom};
      if (kind == KIND_INSERT) begin
        key_log.push_back(key);
        if (key_log.size() > KEY_LOG_MAX) void'(key_log.pop_front());
      end
      send_word(kind, key, 15'($urandom_range(0, 32767)), 1'b0, '0);
      if (i == RAND_WORDS / 2) drain();
      if (burst_left == 0) begin
        burst_left = $urandom_range(0, 4) == 0 ? 60 : $urandom_range(1, 24);
        idle_for($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 10));
      end else begin
        burst_left--;
      end
    end
    drain();
    repeat (40) @(posedge clk_i);
    if (err_cnt == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

/* files.f */
src/chi_pkg.sv
src/chi_ram.sv
src/chi_hash.sv
src/chained_hash_index_core.sv
test/chained_hash_index_core_tb.sv
